// ----- hdl/abd_pkg.sv -----
// shared types, constants and coefficient tables for the adpcm block decoder
// used by every module of the block; no dependencies

package abd_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 24;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned SIZE_W     = 24;
  localparam int unsigned OUT_OFF_W  = 24;
  localparam int unsigned BLOCK_BYTES = 16;
  localparam logic [3:0]  SHIFT_MAX  = 4'd12;
  localparam logic [3:0]  SHIFT_SUB  = 4'd9;
  localparam logic [3:0]  PRED_MAX   = 4'd4;
  localparam logic [7:0]  FLAGS_TERM = 8'd7;
  localparam logic [3:0]  POS_HEADER = 4'd0;
  localparam logic [3:0]  POS_FLAGS  = 4'd1;
  localparam logic [3:0]  POS_FIRST  = 4'd2;
  localparam logic [3:0]  POS_LAST   = 4'd15;

  localparam logic CFG_SAMPLE_SIZE = 1'b0;
  localparam logic CFG_LOOP_ENABLE = 1'b1;

  typedef enum logic [1:0] {
    OP_DATA    = 2'd0,
    OP_TERM    = 2'd1,
    OP_RESTART = 2'd2
  } op_kind_e;

  typedef struct packed {
    op_kind_e              kind;
    logic [7:0]            data;
    logic [3:0]            shift;
    logic [2:0]            pred;
    logic                  last;
    logic [OUT_OFF_W-1:0]  next;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic signed [7:0] coef_a(input logic [2:0] sel);
    logic signed [7:0] c;
    unique case (sel)
      3'd1:    c = 8'sd60;
      3'd2:    c = 8'sd115;
      3'd3:    c = 8'sd98;
      3'd4:    c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [7:0] coef_b(input logic [2:0] sel);
    logic signed [7:0] c;
    unique case (sel)
      3'd2:    c = -8'sd52;
      3'd3:    c = -8'sd55;
      3'd4:    c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/abd_front.sv -----
// front end: accepts input beats, tracks block position, header, flags and offsets
// and queues decode, terminator and restart operations; depends on abd_pkg

module abd_front #(
  parameter int unsigned OFFSET_BITS = abd_pkg::OFFSET_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [abd_pkg::SIZE_W-1:0] cfg_data_i,
  input  logic                       accept_i,
  input  logic                       command_i,
  input  logic [7:0]                 data_byte_i,
  output logic                       push_o,
  output abd_pkg::op_t               op_o
);
  import abd_pkg::*;

  localparam int unsigned CW = ((OFFSET_BITS > SIZE_W) ? OFFSET_BITS : SIZE_W) + 2;

  logic [SIZE_W-1:0]      size_q, size_d;
  logic                   loop_en_q, loop_en_d;
  logic [3:0]             pos_q, pos_d;
  logic [3:0]             shift_q, shift_d;
  logic [2:0]             pred_q, pred_d;
  logic [1:0]             flags_q, flags_d;
  logic [OFFSET_BITS-1:0] boff_q, boff_d;
  logic [OFFSET_BITS-1:0] loff_q, loff_d;
  logic                   ended_q, ended_d;

  logic [CW-1:0]          boff_x, loff_x, size_x, lin_x, next_x, new_x;
  logic [OFFSET_BITS-1:0] boff_new;
  logic                   past_end, wrap;

  always_comb begin
    boff_x   = CW'(boff_q);
    loff_x   = CW'(loff_q);
    size_x   = CW'(size_q);
    lin_x    = boff_x + CW'(BLOCK_BYTES);
    past_end = lin_x > size_x;
    wrap     = ((lin_x + CW'(BLOCK_BYTES)) > size_x) && loop_en_q;
    if (flags_q[0]) begin
      next_x = flags_q[1] ? loff_x : size_x;
    end else begin
      next_x = wrap ? loff_x : lin_x;
    end
    boff_new = next_x[OFFSET_BITS-1:0];
    new_x    = CW'(boff_new);
  end

  always_comb begin
    size_d    = size_q;
    loop_en_d = loop_en_q;
    pos_d     = pos_q;
    shift_d   = shift_q;
    pred_d    = pred_q;
    flags_d   = flags_q;
    boff_d    = boff_q;
    loff_d    = loff_q;
    ended_d   = ended_q;
    push_o    = 1'b0;
    op_o.kind  = OP_DATA;
    op_o.data  = data_byte_i;
    op_o.shift = shift_q;
    op_o.pred  = pred_q;
    op_o.last  = 1'b0;
    op_o.next  = '0;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SAMPLE_SIZE: size_d    = {cfg_data_i[SIZE_W-1:4], 4'b0000};
        CFG_LOOP_ENABLE: loop_en_d = cfg_data_i[0];
        default: ;
      endcase
    end

    if (accept_i) begin
      if (command_i) begin
        push_o    = 1'b1;
        op_o.kind = OP_RESTART;
        boff_d    = '0;
        loff_d    = '0;
        pos_d     = POS_HEADER;
        ended_d   = (size_q[SIZE_W-1:4] == '0);
      end else if (!ended_q) begin
        case (pos_q)
          POS_HEADER: begin
            if (past_end) begin
              ended_d   = 1'b1;
              push_o    = 1'b1;
              op_o.kind = OP_TERM;
              op_o.next = boff_x[OUT_OFF_W-1:0];
            end else begin
              shift_d = (data_byte_i[3:0] > SHIFT_MAX) ? SHIFT_SUB : data_byte_i[3:0];
              pred_d  = (data_byte_i[7:4] > PRED_MAX) ? 3'd0 : data_byte_i[6:4];
              pos_d   = POS_FLAGS;
            end
          end
          POS_FLAGS: begin
            if (data_byte_i == FLAGS_TERM) begin
              ended_d   = 1'b1;
              pos_d     = POS_HEADER;
              push_o    = 1'b1;
              op_o.kind = OP_TERM;
              op_o.next = boff_x[OUT_OFF_W-1:0];
            end else begin
              if (data_byte_i[2]) begin
                loff_d = boff_q;
              end
              flags_d = data_byte_i[1:0];
              pos_d   = POS_FIRST;
            end
          end
          default: begin
            push_o = 1'b1;
            if (pos_q == POS_LAST) begin
              op_o.last = 1'b1;
              op_o.next = new_x[OUT_OFF_W-1:0];
              boff_d    = boff_new;
              pos_d     = POS_HEADER;
            end else begin
              pos_d = pos_q + 4'd1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q    <= '0;
      loop_en_q <= 1'b0;
      pos_q     <= POS_HEADER;
      shift_q   <= '0;
      pred_q    <= '0;
      flags_q   <= '0;
      boff_q    <= '0;
      loff_q    <= '0;
      ended_q   <= 1'b1;
    end else begin
      size_q    <= size_d;
      loop_en_q <= loop_en_d;
      pos_q     <= pos_d;
      shift_q   <= shift_d;
      pred_q    <= pred_d;
      flags_q   <= flags_d;
      boff_q    <= boff_d;
      loff_q    <= loff_d;
      ended_q   <= ended_d;
    end
  end

endmodule

// ----- hdl/abd_queue.sv -----
// short operation queue between front end and decode back end
// register storage, read at the head pointer; depends on abd_pkg

module abd_queue #(
  parameter int unsigned DEPTH = abd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  abd_pkg::op_t           wr_op_i,
  input  logic                   pop_i,
  output abd_pkg::op_t           rd_op_o,
  output abd_pkg::queue_status_t status_o
);
  import abd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  op_t           entry_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + NW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= wr_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign rd_op_o        = entry_q[rd_ptr_q];
  assign status_o.full  = (count_q == NW'(DEPTH));
  assign status_o.empty = (count_q == '0);

endmodule

// ----- hdl/abd_back.sv -----
// back end: two-tap predictor decode of queued bytes, history and output register
// one multiply stage (both taps) and one add/clamp stage per sample; depends on abd_pkg

module abd_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  abd_pkg::op_t           head_i,
  input  abd_pkg::queue_status_t status_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [15:0]     sample_o,
  output logic                   block_last_o,
  output logic                   source_end_o,
  output logic [abd_pkg::OUT_OFF_W-1:0] next_offset_o
);
  import abd_pkg::*;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_MUL  = 3'b010,
    BK_ADD  = 3'b100
  } back_state_e;

  back_state_e         state_q, state_d;
  op_t                 cur_q, cur_d;
  logic                nib_q, nib_d;
  logic signed [15:0]  h1_q, h1_d, h2_q, h2_d;
  logic signed [23:0]  prod_a_q, prod_a_d, prod_b_q, prod_b_d;
  logic                out_valid_q, out_valid_d;
  logic signed [15:0]  sample_q, sample_d;
  logic                last_q, last_d;
  logic                end_q, end_d;
  logic [OUT_OFF_W-1:0] next_q, next_d;

  logic                out_free;
  logic [3:0]          nib;
  logic [15:0]         base, scaled, bias;
  logic signed [16:0]  delta;
  logic signed [24:0]  psum;
  logic signed [18:0]  pred;
  logic signed [19:0]  total;
  logic signed [15:0]  clamped;
  logic signed [7:0]   ca, cb;
  logic                is_last;

  // nibble scaling, prediction and clamp
  always_comb begin
    nib     = nib_q ? cur_q.data[7:4] : cur_q.data[3:0];
    base    = {~nib[3], nib[2:0], 12'b0};
    scaled  = base >> cur_q.shift;
    bias    = 16'h8000 >> cur_q.shift;
    delta   = $signed({1'b0, scaled}) - $signed({1'b0, bias});
    psum    = $signed({prod_a_q[23], prod_a_q}) + $signed({prod_b_q[23], prod_b_q});
    pred    = psum[24:6];
    total   = $signed({pred[18], pred}) + $signed({{3{delta[16]}}, delta});
    if (total > 20'sd32767) begin
      clamped = 16'sh7fff;
    end else if (total < -20'sd32768) begin
      clamped = 16'sh8000;
    end else begin
      clamped = total[15:0];
    end
    ca      = coef_a(cur_q.pred);
    cb      = coef_b(cur_q.pred);
    is_last = cur_q.last && nib_q;
  end

  always_comb begin
    out_free    = !out_valid_q || !out_stall_i;
    state_d     = state_q;
    cur_d       = cur_q;
    nib_d       = nib_q;
    h1_d        = h1_q;
    h2_d        = h2_q;
    prod_a_d    = prod_a_q;
    prod_b_d    = prod_b_q;
    out_valid_d = out_valid_q && out_stall_i;
    sample_d    = sample_q;
    last_d      = last_q;
    end_d       = end_q;
    next_d      = next_q;
    pop_o       = 1'b0;

    unique case (state_q)
      BK_IDLE: begin
        if (!status_i.empty) begin
          unique case (head_i.kind)
            OP_RESTART: begin
              pop_o = 1'b1;
              h1_d  = '0;
              h2_d  = '0;
            end
            OP_TERM: begin
              if (out_free) begin
                pop_o       = 1'b1;
                out_valid_d = 1'b1;
                sample_d    = '0;
                last_d      = 1'b1;
                end_d       = 1'b1;
                next_d      = head_i.next;
              end
            end
            OP_DATA: begin
              pop_o   = 1'b1;
              cur_d   = head_i;
              nib_d   = 1'b0;
              state_d = BK_MUL;
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      BK_MUL: begin
        prod_a_d = $signed({{8{h1_q[15]}}, h1_q}) * $signed({{16{ca[7]}}, ca});
        prod_b_d = $signed({{8{h2_q[15]}}, h2_q}) * $signed({{16{cb[7]}}, cb});
        state_d  = BK_ADD;
      end
      BK_ADD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          sample_d    = clamped;
          last_d      = is_last;
          end_d       = 1'b0;
          next_d      = is_last ? cur_q.next : '0;
          h2_d        = h1_q;
          h1_d        = clamped;
          if (nib_q) begin
            state_d = BK_IDLE;
          end else begin
            nib_d   = 1'b1;
            state_d = BK_MUL;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    prod_a_q <= prod_a_d;
    prod_b_q <= prod_b_d;
    sample_q <= sample_d;
    last_q   <= last_d;
    end_q    <= end_d;
    next_q   <= next_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      nib_q       <= 1'b0;
      h1_q        <= '0;
      h2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nib_q       <= nib_d;
      h1_q        <= h1_d;
      h2_q        <= h2_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sample_o      = sample_q;
  assign block_last_o  = last_q;
  assign source_end_o  = end_q;
  assign next_offset_o = next_q;

endmodule

// ----- hdl/adpcm_block_decoder.sv -----
// top level of the four-bit block adpcm decoder: front end, queue and back end
// depends on abd_pkg, abd_front, abd_queue and abd_back
//
// Usage: bytes of 16-byte blocks arrive on the input channel (in_valid_i,
// in_stall_o, command_i, data_byte_i); a beat with command_i set is a restart
// that clears history and offsets. Byte 0 of a block is shift and predictor,
// byte 1 the flags, bytes 2..15 carry two samples each. Results leave on the
// output channel (out_valid_o, out_stall_i) one sample per beat; the last beat
// of a block carries block_last_o and next_offset_o, a terminator beat also
// source_end_o with a zero sample.
// Header and flag bytes are not queued, but one that ends the source queues a
// terminator. The back end takes each data byte from the queue in its idle
// state, then runs each of its two samples through a multiply state and an
// add/clamp state, in that order set by the dependency through the sample
// history; it takes no new byte until the second sample has been registered.
// The front end runs ahead by up to QUEUE_DEPTH operations; in_stall_o rises
// only when that queue is full. A stalled output holds the back end in its
// add cycle. After reset both registers are zero and the source counts as
// ended, so data bytes are dropped until a restart.
// The configuration port writes sample_size (index 0) or loop_enable (index 1)
// when cfg_we_i is set.

module adpcm_block_decoder #(
  parameter int unsigned OFFSET_BITS = abd_pkg::OFFSET_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = abd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [abd_pkg::SIZE_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [7:0]                    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [15:0]            sample_o,
  output logic                          block_last_o,
  output logic                          source_end_o,
  output logic [abd_pkg::OUT_OFF_W-1:0] next_offset_o
);
  import abd_pkg::*;

  logic          accept;
  logic          q_push, q_pop;
  op_t           q_wr_op, q_rd_op;
  queue_status_t q_status;

  assign in_stall_o = q_status.full;
  assign accept     = in_valid_i && !q_status.full;

  abd_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .push_o      (q_push),
    .op_o        (q_wr_op)
  );

  abd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .wr_op_i  (q_wr_op),
    .pop_i    (q_pop),
    .rd_op_o  (q_rd_op),
    .status_o (q_status)
  );

  abd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (q_rd_op),
    .status_i      (q_status),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_o      (sample_o),
    .block_last_o  (block_last_o),
    .source_end_o  (source_end_o),
    .next_offset_o (next_offset_o)
  );

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_status.full)
    else $error("operation pushed into a full queue");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_status.empty)
    else $error("operation popped from an empty queue");

  a_end_is_terminator: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && source_end_o) |-> (block_last_o && sample_o == 16'sd0))
    else $error("source end beat is not a terminator");

  a_mid_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !block_last_o) |-> (next_offset_o == '0 && !source_end_o))
    else $error("offset reported on a beat inside a block");

endmodule
